[hw/rtl/overwrite_ring_line_buffer_macros.svh]
`ifndef OVERWRITE_RING_LINE_BUFFER_MACROS_SVH
`define OVERWRITE_RING_LINE_BUFFER_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define ORLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define ORLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/orlb_pkg.sv]
`timescale 1ns / 1ps

package orlb_pkg;

  // default geometry
  localparam int LINES_DEF     = 16;
  localparam int LINE_SIZE_DEF = 64;

  // command codes
  localparam logic [2:0] CMD_START      = 3'd0;
  localparam logic [2:0] CMD_LEVEL_CHAR = 3'd1;
  localparam logic [2:0] CMD_END_LEVEL  = 3'd2;
  localparam logic [2:0] CMD_MSG_CHAR   = 3'd3;
  localparam logic [2:0] CMD_END_LINE   = 3'd4;
  localparam logic [2:0] CMD_POP        = 3'd5;
  localparam logic [2:0] CMD_CLEAR      = 3'd6;

  // lost counter and marker
  localparam logic [7:0] LOST_MAX     = 8'd255;
  localparam logic [7:0] MARK_MIN_CAP = 8'd12;
  localparam int         MARK_MAX     = 10;

  // text bytes
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef logic [MARK_MAX-1:0][7:0] mark_msg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  char_in;
    logic [7:0]  cap;
    logic [31:0] timestamp_sec;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic [31:0] stamp_sec;
    logic [7:0]  lines_buffered;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEP,
    ST_META,
    ST_LINE,
    ST_MARK
  } orlb_state_t;

endpackage

[hw/rtl/overwrite_ring_line_buffer.sv]
`timescale 1ns / 1ps

// Ring of timestamped text lines, overwriting the oldest line when full.
// A transaction is taken when start is high and busy is low. Start line,
// level char, message char, end line and clear do not raise busy; end
// level does, since the separator is two bytes through the single
// write port of the byte memory. A pop of a stored line holds busy for
// one metadata memory read, then one byte memory read per output
// byte; a lost marker holds busy while its bytes are produced; an empty pop does
// not raise busy. Results appear one per cycle on out_item, marked by
// out_strobe and registered, line bytes after the byte memory read register;
// the receiver cannot stall them and must take each one in the cycle it is shown.
// Stored bytes and line metadata need no clearing after reset.

`include "overwrite_ring_line_buffer_macros.svh"

module overwrite_ring_line_buffer #(
  parameter int LINES     = orlb_pkg::LINES_DEF,
  parameter int LINE_SIZE = orlb_pkg::LINE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  orlb_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output orlb_pkg::out_item_t out_item
);

  import orlb_pkg::*;

  localparam int SW   = $clog2(LINES);
  localparam int CW   = $clog2(LINES + 1);
  localparam int PW   = $clog2(LINE_SIZE);
  localparam int LW   = $clog2(LINE_SIZE + 1);
  localparam int SUMW = CW + 1;
  localparam int BAW  = SW + PW;
  localparam int MDW  = LW + 32;

  orlb_state_t     state_r, state_nxt;
  logic [SW-1:0]   oldest_r, oldest_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [7:0]      lost_r, lost_nxt;
  logic [SW-1:0]   wslot_r, wslot_nxt;
  logic [LW-1:0]   wpos_r, wpos_nxt;
  logic            open_r, open_nxt;
  logic [SW-1:0]   rslot_r, rslot_nxt;
  logic [PW-1:0]   rpos_r, rpos_nxt;
  logic [PW-1:0]   nm1_r, nm1_nxt;
  logic [7:0]      cap_r, cap_nxt;
  logic [31:0]     stamp_r, stamp_nxt;
  mark_msg_t       msg_r, msg_nxt;
  logic [3:0]      mlen_m1_r, mlen_m1_nxt;
  logic [3:0]      midx_r, midx_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  out_item_t       out_item_r, out_item_nxt;

  // memory ports
  logic            bw_en;
  logic [BAW-1:0]  bw_addr;
  logic [7:0]      bw_data;
  logic            br_en;
  logic [BAW-1:0]  br_addr;
  logic [7:0]      br_data;
  logic            mw_en;
  logic [MDW-1:0]  mw_data;
  logic            mr_en;
  logic [MDW-1:0]  mr_data;

  // helpers
  logic            ring_full;
  logic [SW-1:0]   oldest_inc;
  logic [SW-1:0]   start_oldest;
  logic [CW-1:0]   start_count;
  logic [SUMW-1:0] slot_sum;
  logic [SW-1:0]   start_slot;
  logic            append_ok;
  logic [LW-1:0]   meta_len;
  logic [7:0]      clip_len;
  mark_msg_t       mark_msg;
  logic [3:0]      mark_len_m1;

  orlb_ram #(
    .WIDTH (8),
    .DEPTH (LINES << PW)
  ) u_byte_ram (
    .clk   (clk),
    .we    (bw_en),
    .waddr (bw_addr),
    .wdata (bw_data),
    .re    (br_en),
    .raddr (br_addr),
    .rdata (br_data)
  );

  orlb_ram #(
    .WIDTH (MDW),
    .DEPTH (LINES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (mw_en),
    .waddr (wslot_r),
    .wdata (mw_data),
    .re    (mr_en),
    .raddr (oldest_r),
    .rdata (mr_data)
  );

  orlb_marker u_marker (
    .lost       (lost_r),
    .msg        (mark_msg),
    .msg_len_m1 (mark_len_m1)
  );

  // ring pointer arithmetic
  always_comb begin
    ring_full    = (count_r == CW'(LINES));
    oldest_inc   = (oldest_r == SW'(LINES - 1)) ? '0 : oldest_r + 1'b1;
    start_oldest = ring_full ? oldest_inc : oldest_r;
    start_count  = ring_full ? CW'(LINES - 1) : count_r;
    slot_sum     = SUMW'(start_oldest) + SUMW'(start_count);
    if (slot_sum >= SUMW'(LINES)) begin
      start_slot = SW'(slot_sum - SUMW'(LINES));
    end else begin
      start_slot = SW'(slot_sum);
    end
    append_ok = open_r && (wpos_r < LW'(LINE_SIZE));
    meta_len  = mr_data[MDW-1:32];
    clip_len  = (8'(meta_len) < cap_r) ? 8'(meta_len) : cap_r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      oldest_r     <= '0;
      count_r      <= '0;
      lost_r       <= '0;
      wslot_r      <= '0;
      wpos_r       <= '0;
      open_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      oldest_r     <= oldest_nxt;
      count_r      <= count_nxt;
      lost_r       <= lost_nxt;
      wslot_r      <= wslot_nxt;
      wpos_r       <= wpos_nxt;
      open_r       <= open_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rslot_r    <= rslot_nxt;
    rpos_r     <= rpos_nxt;
    nm1_r      <= nm1_nxt;
    cap_r      <= cap_nxt;
    stamp_r    <= stamp_nxt;
    msg_r      <= msg_nxt;
    mlen_m1_r  <= mlen_m1_nxt;
    midx_r     <= midx_nxt;
    out_item_r <= out_item_nxt;
  end

  // command decode, pop sequencing and memory control
  always_comb begin
    state_nxt      = state_r;
    oldest_nxt     = oldest_r;
    count_nxt      = count_r;
    lost_nxt       = lost_r;
    wslot_nxt      = wslot_r;
    wpos_nxt       = wpos_r;
    open_nxt       = open_r;
    rslot_nxt      = rslot_r;
    rpos_nxt       = rpos_r;
    nm1_nxt        = nm1_r;
    cap_nxt        = cap_r;
    stamp_nxt      = stamp_r;
    msg_nxt        = msg_r;
    mlen_m1_nxt    = mlen_m1_r;
    midx_nxt       = midx_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    bw_en          = 1'b0;
    bw_addr        = {wslot_r, wpos_r[PW-1:0]};
    bw_data        = in_item.char_in;
    br_en          = 1'b0;
    br_addr        = {rslot_r, rpos_r};
    mw_en          = 1'b0;
    mw_data        = {wpos_r, in_item.timestamp_sec};
    mr_en          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_item.cmd)
            CMD_START: begin
              oldest_nxt = start_oldest;
              count_nxt  = start_count;
              if (ring_full && (lost_r != LOST_MAX)) begin
                lost_nxt = lost_r + 8'd1;
              end
              wslot_nxt = start_slot;
              wpos_nxt  = '0;
              open_nxt  = 1'b1;
            end
            CMD_LEVEL_CHAR, CMD_MSG_CHAR: begin
              if (append_ok) begin
                bw_en    = 1'b1;
                wpos_nxt = wpos_r + 1'b1;
              end
            end
            CMD_END_LEVEL: begin
              if (append_ok) begin
                bw_en    = 1'b1;
                bw_data  = CH_COLON;
                wpos_nxt = wpos_r + 1'b1;
              end
              state_nxt = ST_SEP;
            end
            CMD_END_LINE: begin
              if (open_r) begin
                mw_en = 1'b1;
                if (!ring_full) begin
                  count_nxt = count_r + 1'b1;
                end
                open_nxt = 1'b0;
              end
            end
            CMD_POP: begin
              if ((lost_r != 8'd0) && (in_item.cap >= MARK_MIN_CAP)) begin
                msg_nxt     = mark_msg;
                mlen_m1_nxt = mark_len_m1;
                midx_nxt    = '0;
                stamp_nxt   = in_item.timestamp_sec;
                lost_nxt    = '0;
                state_nxt   = ST_MARK;
              end else if (count_r == '0) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '{out_byte: 8'd0, byte_valid: 1'b0,
                                   last_of_run: 1'b1,
                                   stamp_sec: in_item.timestamp_sec,
                                   lines_buffered: 8'(count_r)};
              end else begin
                mr_en      = 1'b1;
                rslot_nxt  = oldest_r;
                cap_nxt    = in_item.cap;
                oldest_nxt = oldest_inc;
                count_nxt  = count_r - 1'b1;
                state_nxt  = ST_META;
              end
            end
            CMD_CLEAR: begin
              oldest_nxt = '0;
              count_nxt  = '0;
              lost_nxt   = '0;
              wslot_nxt  = '0;
              wpos_nxt   = '0;
              open_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      // second separator byte
      ST_SEP: begin
        if (append_ok) begin
          bw_en    = 1'b1;
          bw_data  = CH_SPACE;
          wpos_nxt = wpos_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      // metadata arrived: clip length, start byte reads
      ST_META: begin
        stamp_nxt = mr_data[31:0];
        if (clip_len == 8'd0) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{out_byte: 8'd0, byte_valid: 1'b0, last_of_run: 1'b1,
                             stamp_sec: mr_data[31:0],
                             lines_buffered: 8'(count_r)};
          state_nxt      = ST_IDLE;
        end else begin
          nm1_nxt   = PW'(clip_len - 8'd1);
          rpos_nxt  = '0;
          br_en     = 1'b1;
          br_addr   = {rslot_r, {PW{1'b0}}};
          state_nxt = ST_LINE;
        end
      end
      // one line byte per cycle, next read issued alongside
      ST_LINE: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt   = '{out_byte: br_data, byte_valid: 1'b1,
                           last_of_run: (rpos_r == nm1_r),
                           stamp_sec: stamp_r, lines_buffered: 8'(count_r)};
        if (rpos_r == nm1_r) begin
          state_nxt = ST_IDLE;
        end else begin
          br_en    = 1'b1;
          br_addr  = {rslot_r, rpos_r + 1'b1};
          rpos_nxt = rpos_r + 1'b1;
        end
      end
      // lost marker bytes
      ST_MARK: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt   = '{out_byte: msg_r[midx_r], byte_valid: 1'b1,
                           last_of_run: (midx_r == mlen_m1_r),
                           stamp_sec: stamp_r, lines_buffered: 8'(count_r)};
        if (midx_r == mlen_m1_r) begin
          state_nxt = ST_IDLE;
        end else begin
          midx_nxt = midx_r + 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks
  `ORLB_ASSERT_NOW(a_empty_is_last, out_strobe && !out_item.byte_valid, out_item.last_of_run, "empty result not marked last")
  `ORLB_ASSERT_NOW(a_last_frees, out_strobe && out_item.last_of_run, !busy, "busy after final result of a pop")
  `ORLB_ASSERT_NOW(a_bounds, 1'b1, (count_r <= CW'(LINES)) && (wpos_r <= LW'(LINE_SIZE)), "line count or write position out of range")
  `ORLB_ASSERT_NEXT(a_pop_meta, start && !busy && (in_item.cmd == CMD_POP) && (lost_r == 8'd0) && (count_r != '0), state_r == ST_META, "line pop did not read metadata")

endmodule

[hw/rtl/orlb_ram.sv]
`timescale 1ns / 1ps

module orlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/orlb_marker.sv]
`timescale 1ns / 1ps

module orlb_marker (
  input  logic              [7:0] lost,
  output orlb_pkg::mark_msg_t     msg,
  output logic              [3:0] msg_len_m1
);

  import orlb_pkg::*;

  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [1:0]  ndig;
  logic [1:0]  skip;
  mark_msg_t   full;

  // decimal digits: hundreds by compare, tens by reciprocal multiply
  always_comb begin
    if (lost >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(lost - 8'd200);
    end else if (lost >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(lost - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = 7'(lost);
    end
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - 7'(tens) * 7'd10);
    if (hund != 2'd0) begin
      ndig = 2'd3;
    end else if (tens != 4'd0) begin
      ndig = 2'd2;
    end else begin
      ndig = 2'd1;
    end
    skip = 2'd3 - ndig;
  end

  // full-width text with all three digits, then drop leading zeros
  always_comb begin
    logic [4:0] j;
    full[0] = CH_TILDE;
    full[1] = CH_SPACE;
    full[2] = CH_ZERO + 8'(hund);
    full[3] = CH_ZERO + 8'(tens);
    full[4] = CH_ZERO + 8'(ones);
    full[5] = CH_SPACE;
    full[6] = CH_L;
    full[7] = CH_O;
    full[8] = CH_S;
    full[9] = CH_T;
    for (int i = 0; i < MARK_MAX; i++) begin
      j = 5'(i) + 5'(skip);
      if (i < 2) begin
        msg[i] = full[i];
      end else if (j < 5'(MARK_MAX)) begin
        msg[i] = full[j[3:0]];
      end else begin
        msg[i] = 8'd0;
      end
    end
  end

  assign msg_len_m1 = 4'd6 + 4'(ndig);

endmodule
